>>> hdl/cwmb_pkg.sv
// ----------------------------------------------------------------------------
// cwmb_pkg
// shared widths, register indexes and opcodes of the way mask builder
// ----------------------------------------------------------------------------
package cwmb_pkg;

    localparam int MASK_BITS_DEF = 64;
    localparam int DATA_W        = 64;
    localparam int CNT_W         = 7;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WAYS      = 2'd1;

    localparam logic OP_MASK = 1'b1;

    localparam logic [CNT_W-1:0] MIN_WAYS_RST = 7'd1;

endpackage

>>> hdl/cwmb_scan.sv
// ----------------------------------------------------------------------------
// cwmb_scan
// one register stage of the prefix popcount network over the way vector
// ----------------------------------------------------------------------------
module cwmb_scan #(
    parameter int MASK_BITS = cwmb_pkg::MASK_BITS_DEF,
    parameter int LVL_LO    = 0,
    parameter int LVL_HI    = 3
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  logic                                              in_op,
    input  logic [cwmb_pkg::CNT_W-1:0]                        in_req,
    input  logic [MASK_BITS-1:0]                              in_vec,
    input  logic [MASK_BITS-1:0][$clog2(MASK_BITS+1)-1:0]     in_pre,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output logic                                              out_op,
    output logic [cwmb_pkg::CNT_W-1:0]                        out_req,
    output logic [MASK_BITS-1:0]                              out_vec,
    output logic [MASK_BITS-1:0][$clog2(MASK_BITS+1)-1:0]     out_pre
);

    localparam int PC_W = $clog2(MASK_BITS+1);

    logic                               vld_reg;
    logic                               op_reg;
    logic [cwmb_pkg::CNT_W-1:0]         req_reg;
    logic [MASK_BITS-1:0]               vec_reg;
    logic [MASK_BITS-1:0][PC_W-1:0]     pre_reg;
    logic [MASK_BITS-1:0][PC_W-1:0]     pre_next;

    assign in_ready = !vld_reg || out_ready;

    always_comb
    begin
        logic [MASK_BITS-1:0][PC_W-1:0] pre_prev;
        pre_next = in_pre;
        for (int l = LVL_LO; l < LVL_HI; l++)
        begin
            pre_prev = pre_next;
            for (int i = 0; i < MASK_BITS; i++)
            begin
                if (i >= (1 << l))
                begin
                    pre_next[i] = pre_prev[i] + pre_prev[i - (1 << l)];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg  <= in_op;
            req_reg <= in_req;
            vec_reg <= in_vec;
            pre_reg <= pre_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_op    = op_reg;
    assign out_req   = req_reg;
    assign out_vec   = vec_reg;
    assign out_pre   = pre_reg;

endmodule

>>> hdl/cwmb_pick.sv
// ----------------------------------------------------------------------------
// cwmb_pick
// count clamp, contiguous run search, fallback selection and result stage
// ----------------------------------------------------------------------------
module cwmb_pick #(
    parameter int MASK_BITS = cwmb_pkg::MASK_BITS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic [MASK_BITS-1:0]                              cap,
    input  logic [cwmb_pkg::CNT_W-1:0]                        min_cnt,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  logic                                              in_op,
    input  logic [cwmb_pkg::CNT_W-1:0]                        in_req,
    input  logic [MASK_BITS-1:0]                              in_vec,
    input  logic [MASK_BITS-1:0][$clog2(MASK_BITS+1)-1:0]     in_pre,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output logic [cwmb_pkg::DATA_W-1:0]                       out_mask,
    output logic [cwmb_pkg::CNT_W-1:0]                        out_count,
    output logic                                              out_ok
);

    localparam int PC_W  = $clog2(MASK_BITS+1);
    localparam int CNT_W = cwmb_pkg::CNT_W;

    // stage enables
    logic c_ld;
    logic d_ld;
    logic e_ld;
    logic f_ld;

    // clamp stage
    logic                           c_vld_reg;
    logic                           c_op_reg;
    logic [CNT_W-1:0]               c_cnt_reg;
    logic                           c_okm_reg;
    logic [MASK_BITS-1:0]           c_vec_reg;
    logic [MASK_BITS-1:0][PC_W-1:0] c_pre_reg;
    logic [CNT_W-1:0]               c_cnt_next;
    logic                           c_okm_next;

    // run search stage
    logic                           d_vld_reg;
    logic                           d_op_reg;
    logic [CNT_W-1:0]               d_cnt_reg;
    logic                           d_okm_reg;
    logic [MASK_BITS-1:0]           d_vec_reg;
    logic [MASK_BITS-1:0]           d_hit_reg;
    logic [MASK_BITS-1:0]           d_fb_reg;
    logic [MASK_BITS-1:0]           d_hit_next;
    logic [MASK_BITS-1:0]           d_fb_next;

    // lowest start isolation stage
    logic                           e_vld_reg;
    logic                           e_op_reg;
    logic [CNT_W-1:0]               e_cnt_reg;
    logic                           e_okm_reg;
    logic [MASK_BITS-1:0]           e_vec_reg;
    logic [MASK_BITS-1:0]           e_oh_reg;
    logic                           e_any_reg;
    logic [MASK_BITS-1:0]           e_fb_reg;
    logic [MASK_BITS-1:0]           e_oh_next;

    // result stage
    logic                           f_vld_reg;
    logic [MASK_BITS-1:0]           f_mask_reg;
    logic [CNT_W-1:0]               f_cnt_reg;
    logic                           f_ok_reg;
    logic [MASK_BITS-1:0]           f_mask_next;
    logic                           f_ok_next;

    assign f_ld     = !f_vld_reg || out_ready;
    assign e_ld     = !e_vld_reg || f_ld;
    assign d_ld     = !d_vld_reg || e_ld;
    assign c_ld     = !c_vld_reg || d_ld;
    assign in_ready = c_ld;

    // effective count and mask request check
    always_comb
    begin
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] pc;
        logic [CNT_W-1:0] wc;
        logic             rej;
        lo = (min_cnt == '0) ? CNT_W'(1) : min_cnt;
        pc = CNT_W'(in_pre[MASK_BITS-1]);
        hi = (pc > lo) ? pc : lo;
        if (in_req == '0 || in_req < lo)
        begin
            wc = lo;
        end
        else if (in_req > hi)
        begin
            wc = hi;
        end
        else
        begin
            wc = in_req;
        end
        rej        = pc < lo;
        c_okm_next = !rej;
        c_cnt_next = (in_op == cwmb_pkg::OP_MASK) ? (rej ? '0 : pc) : wc;
    end

    // window of the requested length built from power-of-two run maps
    always_comb
    begin
        logic [CNT_W-1:0][MASK_BITS-1:0] runs;
        logic [MASK_BITS:0]              acc;
        runs[0] = cap;
        for (int k = 1; k < CNT_W; k++)
        begin
            runs[k] = runs[k-1] & (runs[k-1] >> (1 << (k-1)));
        end
        acc = '1;
        for (int k = 0; k < CNT_W; k++)
        begin
            if (c_cnt_reg[k])
            begin
                acc = {1'b0, runs[k]} & (acc >> (1 << k));
            end
        end
        d_hit_next = acc[MASK_BITS-1:0];
        for (int i = 0; i < MASK_BITS; i++)
        begin
            d_fb_next[i] = cap[i] && (CNT_W'(c_pre_reg[i]) <= c_cnt_reg);
        end
    end

    assign e_oh_next = d_hit_reg & (~d_hit_reg + 1'b1);

    always_comb
    begin
        logic [MASK_BITS:0] ext;
        logic [MASK_BITS:0] win;
        ext = {1'b0, e_oh_reg};
        win = (ext << e_cnt_reg) - ext;
        if (e_op_reg == cwmb_pkg::OP_MASK)
        begin
            f_mask_next = e_okm_reg ? e_vec_reg : '0;
            f_ok_next   = e_okm_reg;
        end
        else
        begin
            f_mask_next = e_any_reg ? win[MASK_BITS-1:0] : e_fb_reg;
            f_ok_next   = (f_mask_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else
        begin
            if (c_ld)
            begin
                c_vld_reg <= in_valid;
            end
            if (d_ld)
            begin
                d_vld_reg <= c_vld_reg;
            end
            if (e_ld)
            begin
                e_vld_reg <= d_vld_reg;
            end
            if (f_ld)
            begin
                f_vld_reg <= e_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ld && in_valid)
        begin
            c_op_reg  <= in_op;
            c_cnt_reg <= c_cnt_next;
            c_okm_reg <= c_okm_next;
            c_vec_reg <= in_vec;
            c_pre_reg <= in_pre;
        end
        if (d_ld && c_vld_reg)
        begin
            d_op_reg  <= c_op_reg;
            d_cnt_reg <= c_cnt_reg;
            d_okm_reg <= c_okm_reg;
            d_vec_reg <= c_vec_reg;
            d_hit_reg <= d_hit_next;
            d_fb_reg  <= d_fb_next;
        end
        if (e_ld && d_vld_reg)
        begin
            e_op_reg  <= d_op_reg;
            e_cnt_reg <= d_cnt_reg;
            e_okm_reg <= d_okm_reg;
            e_vec_reg <= d_vec_reg;
            e_oh_reg  <= e_oh_next;
            e_any_reg <= (d_hit_reg != '0);
            e_fb_reg  <= d_fb_reg;
        end
        if (f_ld && e_vld_reg)
        begin
            f_mask_reg <= f_mask_next;
            f_cnt_reg  <= e_cnt_reg;
            f_ok_reg   <= f_ok_next;
        end
    end

    assign out_valid = f_vld_reg;
    assign out_mask  = cwmb_pkg::DATA_W'(f_mask_reg);
    assign out_count = f_cnt_reg;
    assign out_ok    = f_ok_reg;

endmodule

>>> hdl/cache_way_mask_builder.sv
// ----------------------------------------------------------------------------
// cache_way_mask_builder
// stages: an accepted transaction passes through every register stage in order
// (two prefix popcount stages, count clamp, run search, start isolation,
// window) on its way to the output
// throughput: one transaction per cycle; a stalled output holds full stages
// reset: capacity mask 0, minimum ways 1, all pipeline stages empty
// ----------------------------------------------------------------------------
module cache_way_mask_builder #(
    parameter int MASK_BITS = cwmb_pkg::MASK_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cwmb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cwmb_pkg::DATA_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [cwmb_pkg::CNT_W-1:0]         req_ways,
    input  logic [cwmb_pkg::DATA_W-1:0]        req_mask,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cwmb_pkg::DATA_W-1:0]        way_mask,
    output logic [cwmb_pkg::CNT_W-1:0]         way_count,
    output logic                               ok
);

    localparam int PC_W    = $clog2(MASK_BITS+1);
    localparam int LVL_N   = $clog2(MASK_BITS);
    localparam int LVL_MID = LVL_N / 2;

    logic [cwmb_pkg::DATA_W-1:0]        cap_reg;
    logic [cwmb_pkg::CNT_W-1:0]         min_reg;
    logic [MASK_BITS-1:0]               cap;

    logic [MASK_BITS-1:0]               vec_init;
    logic [MASK_BITS-1:0][PC_W-1:0]     pre_init;

    logic                               a_valid;
    logic                               a_ready;
    logic                               a_op;
    logic [cwmb_pkg::CNT_W-1:0]         a_req;
    logic [MASK_BITS-1:0]               a_vec;
    logic [MASK_BITS-1:0][PC_W-1:0]     a_pre;

    logic                               b_valid;
    logic                               b_ready;
    logic                               b_op;
    logic [cwmb_pkg::CNT_W-1:0]         b_req;
    logic [MASK_BITS-1:0]               b_vec;
    logic [MASK_BITS-1:0][PC_W-1:0]     b_pre;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '0;
            min_reg <= cwmb_pkg::MIN_WAYS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cwmb_pkg::REG_CAPACITY_MASK:
                begin
                    cap_reg <= cfg_data;
                end
                cwmb_pkg::REG_MIN_WAYS:
                begin
                    min_reg <= cfg_data[cwmb_pkg::CNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cap = cap_reg[MASK_BITS-1:0];

    // mask requests count only their allowed ways
    always_comb
    begin
        if (op == cwmb_pkg::OP_MASK)
        begin
            vec_init = req_mask[MASK_BITS-1:0] & cap;
        end
        else
        begin
            vec_init = cap;
        end
        for (int i = 0; i < MASK_BITS; i++)
        begin
            pre_init[i] = PC_W'(vec_init[i]);
        end
    end

    cwmb_scan #(
        .MASK_BITS (MASK_BITS),
        .LVL_LO    (0),
        .LVL_HI    (LVL_MID)
    ) u_scan_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (op),
        .in_req    (req_ways),
        .in_vec    (vec_init),
        .in_pre    (pre_init),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_op    (a_op),
        .out_req   (a_req),
        .out_vec   (a_vec),
        .out_pre   (a_pre)
    );

    cwmb_scan #(
        .MASK_BITS (MASK_BITS),
        .LVL_LO    (LVL_MID),
        .LVL_HI    (LVL_N)
    ) u_scan_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_op     (a_op),
        .in_req    (a_req),
        .in_vec    (a_vec),
        .in_pre    (a_pre),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_op    (b_op),
        .out_req   (b_req),
        .out_vec   (b_vec),
        .out_pre   (b_pre)
    );

    cwmb_pick #(
        .MASK_BITS (MASK_BITS)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap),
        .min_cnt   (min_reg),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_op     (b_op),
        .in_req    (b_req),
        .in_vec    (b_vec),
        .in_pre    (b_pre),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_mask  (way_mask),
        .out_count (way_count),
        .out_ok    (ok)
    );

    // accepted transaction lands in the first stage
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> a_valid)
        else $error("accepted transaction missing from first stage");

    // a granted result always carries ways
    a_ok_has_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> way_mask != '0)
        else $error("ok result with empty mask");

    a_ok_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> way_count != '0)
        else $error("ok result with zero way count");

    // rejected or empty results never leak ways
    a_reject_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> way_mask == '0)
        else $error("rejected result with nonzero mask");

endmodule
